/* hw/rtl/integer_to_ascii_formatter_assert.svh */
// Assertion macros shared by the integer-to-ASCII formatter RTL.
`ifndef INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH
`define INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH
`ifndef SYNTHESIS
// The condition must hold in the same cycle as the trigger.
`define ITAF_ASSERT_IMPL(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("formatter assertion failed");
// The condition must hold in the cycle after the trigger.
`define ITAF_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("formatter assertion failed");
`else
`define ITAF_ASSERT_IMPL(lbl, pre, post)
`define ITAF_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

/* hw/rtl/itaf_pkg.sv */
// Types, constants and helper functions of the integer-to-ASCII formatter.
package itaf_pkg;

	// Format codes carried on the request selector.
	localparam logic [2:0] FMT_SDEC = 3'd0;
	localparam logic [2:0] FMT_UDEC = 3'd1;
	localparam logic [2:0] FMT_HEXL = 3'd2;
	localparam logic [2:0] FMT_HEXU = 3'd3;
	localparam logic [2:0] FMT_PTR  = 3'd4;

	// Binary-to-BCD conversion sizes.
	localparam int DEC_BITS   = 32;
	localparam int BCD_DIGITS = 10;
	localparam int BCD_BITS   = 4 * BCD_DIGITS;

	// ASCII characters used as prefixes.
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_X     = 8'h78;

	// Control states of the formatter.
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CONV = 4'b0010,
		ST_SKIP = 4'b0100,
		ST_EMIT = 4'b1000
	} itaf_state_t;

	// Status reported by the BCD converter.
	typedef struct packed {
		logic busy;
		logic done;
	} itaf_dd_status_t;

	// ASCII character of one hex or decimal digit.
	function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
		logic [7:0] base;
		if (d < 4'd10) begin
			base = CH_ZERO;
			digit_char = base + {4'd0, d};
		end else begin
			base = upper ? 8'h41 : 8'h61;
			digit_char = base + {4'd0, d - 4'd10};
		end
	endfunction

endpackage

/* hw/rtl/itaf_dabble.sv */
// Bit-serial binary-to-BCD converter (shift and add three), one bit per cycle.
module itaf_dabble (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [itaf_pkg::DEC_BITS-1:0]       bin,
	output itaf_pkg::itaf_dd_status_t           status,
	output logic [itaf_pkg::BCD_BITS-1:0]       bcd
);
	import itaf_pkg::*;

	localparam int CNT_W = $clog2(DEC_BITS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DEC_BITS - 1);

	logic [DEC_BITS-1:0] bin_q;
	logic [BCD_BITS-1:0] bcd_q;
	logic [BCD_BITS-1:0] corr;
	logic [CNT_W-1:0]    cnt_q;
	logic                busy_q;
	logic                done_q;

	// Add three to every BCD digit of five or more before the next shift.
	always_comb begin
		for (int i = 0; i < BCD_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				corr[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				corr[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	// Sequencing: count the bits shifted in and pulse done at the end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == CNT_LAST);
			if (start) begin
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Data shift registers.
	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= bin;
			bcd_q <= '0;
		end else if (busy_q) begin
			bcd_q <= {corr[BCD_BITS-2:0], bin_q[DEC_BITS-1]};
			bin_q <= {bin_q[DEC_BITS-2:0], 1'b0};
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign bcd         = bcd_q;

endmodule

/* hw/rtl/integer_to_ascii_formatter.sv */
// Top level of the integer-to-ASCII formatter.
//
// A request enters on the slave stream: s_tuser carries the format code
// (signed decimal, unsigned decimal, lower hex, upper hex, pointer) and
// s_tdata the 64-bit argument. The block emits the ASCII text on the
// master stream, most significant character first, one per beat; the
// final character has m_tlast set and carries the character count.
// Unknown format codes are accepted and produce no output.
// One request is handled at a time. Decimal formats pass through the
// bit-serial BCD converter; then leading zeros are stripped and the
// characters are emitted. Hex and pointer formats skip the converter,
// and unknown codes leave the formatter waiting for the next request.
// The output register decouples the sides: a new request is taken as
// soon as the last character has been loaded, even while it waits. A
// stalled receiver simply holds the current character and pauses the
// emitter. Reset clears all control state and drops any pending
// output.
module integer_to_ascii_formatter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [63:0] value
	input  logic [2:0]  s_tuser,   // [2:0] req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] out_char, [12:8] char_count, [15:13] zero
	output logic        m_tlast    // last
);
	import itaf_pkg::*;

	itaf_state_t         state_q;
	logic [63:0]         dig_q;
	logic [4:0]          rem_q;
	logic [4:0]          cnt_q;
	logic [1:0]          pre_q;
	logic                ptr_q;
	logic                upper_q;
	logic                m_valid_q;
	logic [7:0]          m_char_q;
	logic [4:0]          m_count_q;
	logic                m_last_q;

	logic                s_acc;
	logic                out_free;
	logic                neg;
	logic [31:0]         low32;
	logic [31:0]         mag;
	logic                dd_start;
	itaf_dd_status_t     dd_status;
	logic [BCD_BITS-1:0] dd_bcd;
	logic [7:0]          pre_char;

	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;

	// Magnitude of the low word for the decimal formats.
	assign low32    = s_tdata[31:0];
	assign neg      = (s_tuser == FMT_SDEC) && low32[31];
	assign mag      = neg ? (~low32 + 32'd1) : low32;
	assign dd_start = s_acc && ((s_tuser == FMT_SDEC) || (s_tuser == FMT_UDEC));

	itaf_dabble u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dd_start),
		.bin    (mag),
		.status (dd_status),
		.bcd    (dd_bcd)
	);

	// Prefix character: "0x" for pointers, '-' for negative decimals.
	always_comb begin
		if (ptr_q && (pre_q == 2'd2)) begin
			pre_char = CH_ZERO;
		end else if (ptr_q) begin
			pre_char = CH_X;
		end else begin
			pre_char = CH_MINUS;
		end
	end

	// Control state machine and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			m_valid_q <= ((state_q == ST_EMIT) && out_free) || (m_valid_q && !m_tready);
			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						unique case (s_tuser) inside
							FMT_SDEC, FMT_UDEC: state_q <= ST_CONV;
							FMT_HEXL, FMT_HEXU, FMT_PTR: state_q <= ST_SKIP;
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_CONV: begin
					if (dd_status.done) begin
						state_q <= ST_SKIP;
					end
				end
				ST_SKIP: begin
					if (!((dig_q[63:60] == 4'd0) && (rem_q > 5'd1))) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free && (pre_q == 2'd0) && (rem_q == 5'd1)) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Digit register, counters and output payload.
	always_ff @(posedge clk) begin
		if (s_acc) begin
			cnt_q   <= '0;
			ptr_q   <= (s_tuser == FMT_PTR);
			upper_q <= (s_tuser == FMT_HEXU);
			if (s_tuser == FMT_PTR) begin
				pre_q <= 2'd2;
				dig_q <= s_tdata;
				rem_q <= 5'd16;
			end else begin
				pre_q <= neg ? 2'd1 : 2'd0;
				dig_q <= {low32, 32'd0};
				rem_q <= 5'd8;
			end
		end
		unique case (state_q)
			ST_CONV: begin
				if (dd_status.done) begin
					dig_q <= {dd_bcd, {(64 - BCD_BITS){1'b0}}};
					rem_q <= 5'(BCD_DIGITS);
				end
			end
			ST_SKIP: begin
				if ((dig_q[63:60] == 4'd0) && (rem_q > 5'd1)) begin
					dig_q <= {dig_q[59:0], 4'd0};
					rem_q <= rem_q - 5'd1;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					cnt_q <= cnt_q + 5'd1;
					if (pre_q != 2'd0) begin
						m_char_q  <= pre_char;
						m_last_q  <= 1'b0;
						m_count_q <= '0;
						pre_q     <= pre_q - 2'd1;
					end else begin
						m_char_q  <= digit_char(dig_q[63:60], upper_q);
						m_last_q  <= (rem_q == 5'd1);
						m_count_q <= (rem_q == 5'd1) ? (cnt_q + 5'd1) : 5'd0;
						dig_q     <= {dig_q[59:0], 4'd0};
						rem_q     <= rem_q - 5'd1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {3'd0, m_count_q, m_char_q};
	assign m_tlast  = m_last_q;

	// Checks on the emitter and the converter hand-off.
`include "integer_to_ascii_formatter_assert.svh"
	`ITAF_ASSERT_IMPL(a_last_count, m_tvalid && m_tlast, (m_count_q != 5'd0) && (m_count_q <= 5'd18))
	`ITAF_ASSERT_IMPL(a_mid_count, m_tvalid && !m_tlast, m_count_q == 5'd0)
	`ITAF_ASSERT_IMPL(a_conv_done, dd_status.done || dd_status.busy, state_q == ST_CONV)
	`ITAF_ASSERT_NEXT(a_busy_after, s_acc && (s_tuser <= FMT_PTR), !s_tready)

endmodule
